FILE: rtl/swgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swgc_pkg;

  // Default sizes handed to the top level
  localparam int MAX_WINDOW_DEF    = 127;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed field widths
  localparam int CNT_W = 7;
  localparam int POS_W = 32;
  localparam int CHR_W = 8;

  // Register value after reset
  localparam logic [CNT_W-1:0] WINDOW_LEN_RST = 7'd21;

  // Characters with a meaning of their own
  localparam logic [CHR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHR_W-1:0] CH_HEADER  = 8'h3E;

  // Parsing phase of the current record
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_FILL   = 2'd1,
    PH_STEADY = 2'd2
  } phase_t;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_POP   = 3'd1,
    ST_START = 3'd2,
    ST_DIV   = 3'd3,
    ST_LOAD  = 3'd4
  } seq_state_t;

  // Control shared by every window cell
  typedef struct packed {
    logic             clr;
    logic             shift;
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    logic             wr_bit;
  } cell_ctrl_t;

  // A, C, G or T in either case
  function automatic logic is_base(input logic [CHR_W-1:0] c);
    return (c == 8'h61) || (c == 8'h41) || (c == 8'h63) || (c == 8'h43) ||
           (c == 8'h67) || (c == 8'h47) || (c == 8'h74) || (c == 8'h54);
  endfunction

  // C or G in either case
  function automatic logic is_gc(input logic [CHR_W-1:0] c);
    return (c == 8'h63) || (c == 8'h43) || (c == 8'h67) || (c == 8'h47);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/swgc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One window slot. Slot 0 holds the oldest base; a pop moves every slot
// one place toward slot 0, and a push writes the slot at the fill level.
module swgc_cell #(
  parameter int INDEX = 0
) (
  input  wire                  clk,
  input  wire swgc_pkg::cell_ctrl_t ctrl,
  input  wire                  from_right,
  output logic                 gc_bit
);
  import swgc_pkg::*;

  logic hit;

  assign hit = ctrl.wr_en && (ctrl.wr_idx == CNT_W'(INDEX));

  // Clear, write or take the neighbor's bit
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      gc_bit <= 1'b0;
    end else if (hit) begin
      gc_bit <= ctrl.wr_bit;
    end else if (ctrl.shift) begin
      gc_bit <= from_right;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swgc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider for dividend * 2^FRACTION_BITS / divisor, where the
// dividend never exceeds the divisor. One quotient bit per cycle,
// FRACTION_BITS + 1 quotient bits, then a one-cycle done pulse.
module swgc_div #(
  parameter int FRACTION_BITS = swgc_pkg::FRACTION_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [swgc_pkg::CNT_W-1:0]   dividend,
  input  wire  [swgc_pkg::CNT_W-1:0]   divisor,
  output logic                         done,
  output logic [FRACTION_BITS:0]       quotient
);
  import swgc_pkg::*;

  localparam int CW = $clog2(FRACTION_BITS + 2);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic                   first;
  logic                   zero_div;
  logic [CNT_W-1:0]       rem;
  logic [CNT_W-1:0]       dsr;
  logic [FRACTION_BITS:0] q;
  logic [CNT_W:0]         trial;
  logic                   qbit;
  logic [CNT_W-1:0]       rem_next;

  // One trial subtraction per cycle
  always_comb begin
    trial    = first ? {1'b0, rem} : {rem, 1'b0};
    qbit     = trial >= {1'b0, dsr};
    rem_next = qbit ? CNT_W'(trial - {1'b0, dsr}) : CNT_W'(trial);
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(FRACTION_BITS + 1);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsr      <= divisor;
      first    <= 1'b1;
      zero_div <= (divisor == '0);
      q        <= '0;
    end else if (busy) begin
      rem   <= rem_next;
      first <= 1'b0;
      q     <= {q[FRACTION_BITS-1:0], qbit};
    end
  end

  // An empty window reads as a zero fraction.
  assign quotient = zero_div ? '0 : q;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_gc_content.sv
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window GC content over a FASTA character stream.
// Input channel s_axis: one ASCII character per transfer in tdata; tlast
// marks end of stream (the character is then ignored and the open record
// is drained). Output channel m_axis: one result per transfer; tlast marks
// the final result caused by an input transfer, tuser marks a short record.
// Configuration channel cfg: writes window_len, clears the window and
// returns to header skipping; it is always ready. The user must write it
// only while idle; the block does not enforce this. Timing: a character
// that causes no result is taken while the sequencer is idle. Each result
// waits on the bit-serial divider that forms the fraction; a record end
// gives window/2 results in a row, each after one pop of the cell chain.
// The output register holds a result while the receiver stalls; the next
// character is taken as soon as the last result of the current one sits in
// that register. A stall stops the sequencer before the next load only.
// Reset: window_len returns to 21, the window is empty, and the block
// skips text until the first newline.
module sliding_window_gc_content #(
  parameter int MAX_WINDOW    = swgc_pkg::MAX_WINDOW_DEF,
  parameter int FRACTION_BITS = swgc_pkg::FRACTION_BITS_DEF,
  localparam int PAYLOAD_W = 2 * swgc_pkg::CNT_W + FRACTION_BITS + 1 + swgc_pkg::POS_W,
  localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8
) (
  input  wire                        clk,
  input  wire                        rst,
  // Configuration: window_len
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [swgc_pkg::CNT_W-1:0] cfg_data,
  // tdata: stream_byte; tlast: end_of_stream
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire  [swgc_pkg::CHR_W-1:0] s_axis_tdata,
  input  wire                        s_axis_tlast,
  // tdata: gc_count, base_count, gc_fraction, position, zero fill
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [TDATA_W-1:0]         m_axis_tdata,
  // tlast: last; tuser: short_record
  output logic                       m_axis_tlast,
  output logic                       m_axis_tuser
);
  import swgc_pkg::*;

  localparam logic [CNT_W-1:0] W_CAP = CNT_W'((MAX_WINDOW - 1) | 1);

  seq_state_t           state, state_next;
  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     window_len;
  logic [CNT_W-1:0]     held;
  logic [CNT_W-1:0]     gc;
  logic [POS_W-1:0]     pos, pos_next, pos_inc;
  logic [POS_W-1:0]     res_pos, res_pos_next;
  logic                 res_short, res_short_next;
  logic                 res_last, res_last_next;
  logic                 clr_after, clr_after_next;
  logic [CNT_W-2:0]     drain_left, drain_left_next;

  logic [CNT_W-1:0]     w_raw, w_eff, half;
  logic [CNT_W:0]       held_inc, half_inc;
  logic                 cfg_fire, push, pop, clear, div_start, load;
  logic                 new_gc;
  logic                 div_done;
  logic [FRACTION_BITS:0] div_q;
  cell_ctrl_t           ctrl;
  logic [MAX_WINDOW:0]  bits;

  assign cfg_ready     = 1'b1;
  assign cfg_fire      = cfg_valid;
  assign s_axis_tready = (state == ST_IDLE);
  assign new_gc        = is_gc(s_axis_tdata);

  // Effective odd window and its half
  always_comb begin
    w_raw    = window_len | CNT_W'(1);
    w_eff    = (w_raw > W_CAP) ? W_CAP : w_raw;
    half     = w_eff >> 1;
    held_inc = {1'b0, held} + (CNT_W + 1)'(1);
    half_inc = {1'b0, half} + (CNT_W + 1)'(1);
    pos_inc  = (pos == '1) ? pos : pos + POS_W'(1);
  end

  // Sequencer: parse, pop, divide, load
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    push            = 1'b0;
    pop             = 1'b0;
    clear           = 1'b0;
    div_start       = 1'b0;
    load            = 1'b0;
    pos_next        = pos;
    res_pos_next    = res_pos;
    res_short_next  = res_short;
    res_last_next   = res_last;
    clr_after_next  = clr_after;
    drain_left_next = drain_left;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (phase)
            PH_FILL, PH_STEADY: begin
              if (s_axis_tlast || (s_axis_tdata == CH_HEADER)) begin
                // Record end
                phase_next = PH_HEADER;
                if ({1'b0, held} < half_inc) begin
                  res_pos_next   = POS_W'(1);
                  res_short_next = 1'b1;
                  res_last_next  = 1'b1;
                  clr_after_next = 1'b1;
                  state_next     = ST_START;
                end else if (half == '0) begin
                  clear = 1'b1;
                end else begin
                  drain_left_next = half[CNT_W-2:0];
                  res_short_next  = 1'b0;
                  state_next      = ST_POP;
                end
              end else if (s_axis_tdata == CH_NEWLINE) begin
                state_next = ST_IDLE;
              end else if (phase == PH_FILL) begin
                if (is_base(s_axis_tdata) && (held < w_eff)) begin
                  push = 1'b1;
                  if (held_inc >= half_inc) begin
                    pos_next       = pos_inc;
                    res_pos_next   = pos_inc;
                    res_short_next = 1'b0;
                    res_last_next  = 1'b1;
                    clr_after_next = 1'b0;
                    state_next     = ST_START;
                  end
                  if (held_inc >= {1'b0, w_eff}) begin
                    phase_next = PH_STEADY;
                  end
                end
              end else begin
                // Full window: drop the oldest, take the new character
                pop            = (held >= w_eff) && (held != '0);
                push           = 1'b1;
                pos_next       = pos_inc;
                res_pos_next   = pos_inc;
                res_short_next = 1'b0;
                res_last_next  = 1'b1;
                clr_after_next = 1'b0;
                state_next     = ST_START;
              end
            end
            default: begin
              // Header skip, also for the unused code
              if (!s_axis_tlast && (s_axis_tdata == CH_NEWLINE)) begin
                clear      = 1'b1;
                phase_next = PH_FILL;
              end else begin
                phase_next = PH_HEADER;
              end
            end
          endcase
        end
      end
      ST_POP: begin
        pop             = 1'b1;
        pos_next        = pos_inc;
        res_pos_next    = pos_inc;
        res_last_next   = (drain_left == (CNT_W - 1)'(1));
        clr_after_next  = (drain_left == (CNT_W - 1)'(1));
        drain_left_next = drain_left - (CNT_W - 1)'(1);
        state_next      = ST_START;
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load = 1'b1;
          if (res_last) begin
            clear      = clr_after;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_POP;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_HEADER;
      window_len <= WINDOW_LEN_RST;
      held       <= '0;
      gc         <= '0;
      pos        <= '0;
      drain_left <= '0;
      res_last   <= 1'b0;
      clr_after  <= 1'b0;
    end else if (cfg_fire) begin
      state      <= ST_IDLE;
      phase      <= PH_HEADER;
      window_len <= cfg_data;
      held       <= '0;
      gc         <= '0;
      pos        <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      drain_left <= drain_left_next;
      res_last   <= res_last_next;
      clr_after  <= clr_after_next;
      if (clear) begin
        held <= '0;
        gc   <= '0;
        pos  <= '0;
      end else begin
        held <= held + CNT_W'(push) - CNT_W'(pop);
        gc   <= gc + CNT_W'(push & new_gc) - CNT_W'(pop & bits[0]);
        pos  <= pos_next;
      end
    end
  end

  // Result fields waiting for the divider
  always_ff @(posedge clk) begin
    res_pos   <= res_pos_next;
    res_short <= res_short_next;
  end

  // Window cell chain
  always_comb begin
    ctrl.clr    = rst || cfg_fire || clear;
    ctrl.shift  = pop;
    ctrl.wr_en  = push;
    ctrl.wr_idx = held - CNT_W'(pop);
    ctrl.wr_bit = new_gc;
  end

  assign bits[MAX_WINDOW] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swgc_cell #(
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .from_right(bits[i+1]),
      .gc_bit    (bits[i])
    );
  end

  // Fraction unit
  swgc_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(gc),
    .divisor (held),
    .done    (div_done),
    .quotient(div_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= TDATA_W'({res_pos, div_q, held, gc});
      m_axis_tlast <= res_last;
      m_axis_tuser <= res_short;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swgc_check.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the GC content block.
module swgc_check #(
  parameter int FRACTION_BITS = swgc_pkg::FRACTION_BITS_DEF,
  parameter int TDATA_W       = 64
) (
  input wire               clk,
  input wire               rst,
  input wire               m_axis_tvalid,
  input wire               m_axis_tready,
  input wire [TDATA_W-1:0] m_axis_tdata,
  input wire               m_axis_tlast,
  input wire               m_axis_tuser
);
  import swgc_pkg::*;

  logic [CNT_W-1:0]       gc_f;
  logic [CNT_W-1:0]       base_f;
  logic [FRACTION_BITS:0] frac_f;
  logic [POS_W-1:0]       pos_f;

  assign gc_f   = m_axis_tdata[CNT_W-1:0];
  assign base_f = m_axis_tdata[2*CNT_W-1:CNT_W];
  assign frac_f = m_axis_tdata[2*CNT_W+FRACTION_BITS:2*CNT_W];
  assign pos_f  = m_axis_tdata[2*CNT_W+FRACTION_BITS+POS_W:2*CNT_W+FRACTION_BITS+1];

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // The window never counts more C/G than it holds, and the fraction stays at or below one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (gc_f <= base_f) &&
      (frac_f <= (FRACTION_BITS + 1)'(1) << FRACTION_BITS))
    else $error("count or fraction out of range");

  // A short record is a single final result at position one.
  a_short: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (pos_f == POS_W'(1)))
    else $error("short record result malformed");

  // An empty window only appears as a short record with a zero fraction.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (base_f == '0) |-> m_axis_tuser && (frac_f == '0))
    else $error("empty window result malformed");

endmodule

bind sliding_window_gc_content swgc_check #(
  .FRACTION_BITS(FRACTION_BITS),
  .TDATA_W      (TDATA_W)
) u_swgc_check (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
